// File: design/lpad_pkg.sv
// shared types and constants for the length-prefixed argument deframer
`timescale 1ns / 1ps
`default_nettype none

package lpad_pkg;

	// default upper bound on the argument count of one frame
	localparam int ARG_LIMIT_DEF = 1024;

	// result queue depth
	localparam int OUTQ_DEPTH = 4;

	// result kinds
	localparam logic [1:0] KIND_ARG_BYTE  = 2'd0;
	localparam logic [1:0] KIND_ARG_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ACCEPT    = 2'd2;
	localparam logic [1:0] KIND_REJECT    = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;
	localparam logic [1:0] ERR_TRAILING  = 2'd3;

	// one result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  err;
		logic [9:0]  idx;
		logic [7:0]  data;
		logic        arg_end;
		logic [10:0] count;
		logic        last;
	} lpad_result_t;

	// results produced by one accepted byte: n of them, r0 first
	typedef struct packed {
		logic [1:0]   n;
		lpad_result_t r0;
		lpad_result_t r1;
	} lpad_push_t;

endpackage

`default_nettype wire

// File: design/lpad_in_if.sv
// byte channel into the deframer
`timescale 1ns / 1ps
`default_nettype none

interface lpad_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source(output valid, output data_byte, output frame_last, input ready);
	modport sink(input valid, input data_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// File: design/lpad_out_if.sv
// result channel out of the deframer
`timescale 1ns / 1ps
`default_nettype none

interface lpad_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [1:0]  error_code;
	logic [9:0]  arg_index;
	logic [7:0]  arg_byte;
	logic        arg_end;
	logic [10:0] arg_count;
	logic        last;

	modport source(output valid, output result_kind, output error_code, output arg_index,
		output arg_byte, output arg_end, output arg_count, output last, input ready);
	modport sink(input valid, input result_kind, input error_code, input arg_index,
		input arg_byte, input arg_end, input arg_count, input last, output ready);
endinterface

`default_nettype wire

// File: design/lpad_parse.sv
// frame parser: per-byte state update and result generation
`timescale 1ns / 1ps
`default_nettype none

module lpad_parse #(
	parameter int ARG_LIMIT = lpad_pkg::ARG_LIMIT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         data_byte,
	input  wire logic               frame_last,
	output lpad_pkg::lpad_push_t    push
);
	import lpad_pkg::*;

	localparam int CNT_W = $clog2(ARG_LIMIT + 1);

	// parser phases
	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [1:0]       phase_q, phase_n;
	logic [1:0]       pos_q, pos_n;
	logic [23:0]      accum_q, accum_n;
	logic [31:0]      left_q, left_n;
	logic [CNT_W-1:0] expected_q, expected_n;
	logic [CNT_W-1:0] done_q, done_n;
	logic [1:0]       perr_q, perr_n;

	logic [31:0]      word;
	logic             field_full;
	logic [CNT_W:0]   done_inc;
	logic             data_vld;
	logic             data_end;
	lpad_result_t     data_res;
	lpad_result_t     fin_res;

	assign word       = {data_byte, accum_q};
	assign field_full = (pos_q == 2'd3);
	assign done_inc   = {1'b0, done_q} + 1'b1;
	assign data_end   = (left_q <= 32'd1);

	// next state and results for the byte on the input
	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		accum_n    = accum_q;
		left_n     = left_q;
		expected_n = expected_q;
		done_n     = done_q;
		perr_n     = perr_q;
		data_vld   = 1'b0;
		data_res   = '0;
		fin_res    = '0;
		push       = '0;

		if (perr_q == ERR_NONE) begin
			// length and count fields: collect little-endian bytes
			if (phase_q == PH_COUNT || phase_q == PH_LEN) begin
				pos_n = pos_q + 2'd1;
				case (pos_q)
					2'd0: accum_n[7:0]   = data_byte;
					2'd1: accum_n[15:8]  = data_byte;
					2'd2: accum_n[23:16] = data_byte;
					default: accum_n     = '0;
				endcase
			end
			case (phase_q)
				PH_COUNT: begin
					if (field_full) begin
						if (word > 32'(ARG_LIMIT)) begin
							perr_n = ERR_TOO_MANY;
						end else begin
							expected_n = word[CNT_W-1:0];
							done_n     = '0;
							phase_n    = (word == 32'd0) ? PH_DONE : PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (field_full) begin
						if (word == 32'd0) begin
							data_vld         = 1'b1;
							data_res.kind    = KIND_ARG_EMPTY;
							data_res.idx     = 10'(done_q);
							data_res.arg_end = 1'b1;
							done_n  = done_inc[CNT_W-1:0];
							phase_n = (done_inc >= {1'b0, expected_q}) ? PH_DONE : PH_LEN;
						end else begin
							left_n  = word;
							phase_n = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					data_vld         = 1'b1;
					data_res.kind    = KIND_ARG_BYTE;
					data_res.idx     = 10'(done_q);
					data_res.data    = data_byte;
					data_res.arg_end = data_end;
					left_n = data_end ? 32'd0 : left_q - 32'd1;
					if (data_end) begin
						done_n  = done_inc[CNT_W-1:0];
						phase_n = (done_inc >= {1'b0, expected_q}) ? PH_DONE : PH_LEN;
					end
				end
				default: begin
					perr_n = ERR_TRAILING;
				end
			endcase
		end

		// frame verdict from the updated state
		fin_res.last = 1'b1;
		if (perr_n != ERR_NONE) begin
			fin_res.kind = KIND_REJECT;
			fin_res.err  = perr_n;
		end else if (phase_n != PH_DONE) begin
			fin_res.kind = KIND_REJECT;
			fin_res.err  = ERR_TRUNCATED;
		end else begin
			fin_res.kind  = KIND_ACCEPT;
			fin_res.count = 11'(expected_n);
		end

		// order the results: data first, verdict last
		if (accept) begin
			if (frame_last) begin
				if (data_vld) begin
					push.n  = 2'd2;
					push.r0 = data_res;
					push.r1 = fin_res;
				end else begin
					push.n  = 2'd1;
					push.r0 = fin_res;
				end
			end else if (data_vld) begin
				push.n       = 2'd1;
				push.r0      = data_res;
				push.r0.last = 1'b1;
			end
		end
	end

	// parser state, back to reset values at the end of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			pos_q      <= '0;
			accum_q    <= '0;
			left_q     <= '0;
			expected_q <= '0;
			done_q     <= '0;
			perr_q     <= ERR_NONE;
		end else if (accept) begin
			if (frame_last) begin
				phase_q    <= PH_COUNT;
				pos_q      <= '0;
				accum_q    <= '0;
				left_q     <= '0;
				expected_q <= '0;
				done_q     <= '0;
				perr_q     <= ERR_NONE;
			end else begin
				phase_q    <= phase_n;
				pos_q      <= pos_n;
				accum_q    <= accum_n;
				left_q     <= left_n;
				expected_q <= expected_n;
				done_q     <= done_n;
				perr_q     <= perr_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/lpad_outq.sv
// result queue: takes up to two words per cycle, hands out one
`timescale 1ns / 1ps
`default_nettype none

module lpad_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  lpad_pkg::lpad_push_t  push,
	output logic                  room,
	lpad_out_if.source            results
);
	import lpad_pkg::*;

	localparam int PTR_W = $clog2(OUTQ_DEPTH);
	localparam int CW    = $clog2(OUTQ_DEPTH + 1);

	lpad_result_t     entry_q [OUTQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W-1:0] wr_nxt;
	logic [CW-1:0]    count_q;
	logic             pop;
	lpad_result_t     head;

	assign wr_nxt = wr_ptr_q + PTR_W'(1);
	assign pop    = results.valid && results.ready;
	assign room   = (count_q <= CW'(OUTQ_DEPTH - 2));
	assign head   = entry_q[rd_ptr_q];

	// head of the queue drives the channel
	assign results.valid       = (count_q != '0);
	assign results.result_kind = head.kind;
	assign results.error_code  = head.err;
	assign results.arg_index   = head.idx;
	assign results.arg_byte    = head.data;
	assign results.arg_end     = head.arg_end;
	assign results.arg_count   = head.count;
	assign results.last        = head.last;

	// storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[wr_nxt] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: design/length_prefixed_arg_deframer.sv
// top level of the length-prefixed argument deframer
//
// frames: one frame byte per word, frame_last set on the final byte. A frame
//   is a 4-byte little-endian argument count, then per argument a 4-byte
//   little-endian length and its data bytes.
// results: one word per data byte (argument index, end mark), one word per
//   empty argument, and one accept or reject word at the end of the frame.
// Flow: results of a byte go into the result queue when the byte is taken
//   and reach the result channel from there. One byte per cycle while the
//   result queue has room; a final byte that also carries data gives two
//   words, which the result side hands out one after the other.
// A four-word result queue sits between parser and output; frames.ready is
//   high while two entries are free, so a stalled receiver backs the input
//   up once three words are waiting and nothing is lost.
// After an error all bytes up to frame_last are dropped, then one reject
//   word with the first error is given.
// Reset: parser waits for an argument count, result queue is empty.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_arg_deframer #(
	parameter int ARG_LIMIT = lpad_pkg::ARG_LIMIT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lpad_in_if.sink     frames,
	lpad_out_if.source  results
);
	import lpad_pkg::*;

	lpad_push_t push;
	logic       room;
	logic       accept;

	assign frames.ready = room;
	assign accept       = frames.valid && room;

	// per-byte parser
	lpad_parse #(
		.ARG_LIMIT(ARG_LIMIT)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (frames.data_byte),
		.frame_last (frames.frame_last),
		.push       (push)
	);

	// result queue
	lpad_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

	// a frame end always leaves a verdict word waiting
	a_fin_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.ready && frames.frame_last |=> results.valid)
		else $error("no result after frame end");

	// accept word closes its byte and carries no error
	a_accept_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.result_kind == KIND_ACCEPT |->
		results.last && results.error_code == ERR_NONE)
		else $error("malformed accept word");

	// reject word always names an error
	a_reject_err: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.result_kind == KIND_REJECT |->
		results.error_code != ERR_NONE && results.last)
		else $error("reject word without error code");

	// empty argument always ends its argument
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.result_kind == KIND_ARG_EMPTY |-> results.arg_end)
		else $error("empty argument without end mark");

endmodule

`default_nettype wire
